// ----- hdl/eul2rm_pkg.sv -----
// ----------------------------------------------------------------------------
// eul2rm_pkg
// Shared types, constants and arithmetic helpers for the euler to matrix block.
// ----------------------------------------------------------------------------
package eul2rm_pkg;

    localparam int OUT_FRAC_BITS_DEF = 14;
    localparam int CORDIC_ITERS      = 23;
    localparam int ANG_W             = 16;
    localparam int VEC_W             = 33;
    localparam int Z_W               = 24;
    localparam int FULL_TURN         = 23040;
    localparam int QUARTER_TURN      = 5760;
    localparam int CORDIC_ONE        = 652032874;
    localparam int OUT_W             = 16;
    localparam int NOUT              = 9;
    localparam int LATENCY           = CORDIC_ITERS + 5;

    localparam int ATAN_TBL [CORDIC_ITERS] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1
    };

    // one angle on its way through the rotator
    typedef struct packed {
        logic signed [VEC_W-1:0] x;
        logic signed [VEC_W-1:0] y;
        logic signed [Z_W-1:0]   z;
        logic [1:0]              quad;
    } cord_t;

    // q30 product rounded to nearest, ties toward plus infinity
    function automatic logic signed [VEC_W-1:0] mulq30(
        input logic signed [VEC_W-1:0] a,
        input logic signed [VEC_W-1:0] b
    );
        logic signed [2*VEC_W-1:0] p;
        p = a * b;
        p = p + (2*VEC_W)'(64'sd1 <<< 29);
        p = p >>> 30;
        return p[VEC_W-1:0];
    endfunction

endpackage

// ----- hdl/eul2rm_wrap.sv -----
// ----------------------------------------------------------------------------
// eul2rm_wrap
// Wraps the three angles into one turn and splits quadrant and remainder.
// ----------------------------------------------------------------------------
module eul2rm_wrap
    import eul2rm_pkg::*;
(
    input  logic                    aclk,
    input  logic                    en,
    input  logic signed [ANG_W-1:0] pitch_angle,
    input  logic signed [ANG_W-1:0] yaw_angle,
    input  logic signed [ANG_W-1:0] roll_angle,
    output cord_t                   pitch_o,
    output cord_t                   yaw_o,
    output cord_t                   roll_o
);

    function automatic cord_t start(input logic signed [ANG_W-1:0] ang);
        logic signed [17:0] a;
        logic signed [17:0] r;
        cord_t              c;
        a = 18'(ang);
        if (a < 0) begin
            if (a < -18'(FULL_TURN)) begin
                a = a + 18'(2 * FULL_TURN);
            end else begin
                a = a + 18'(FULL_TURN);
            end
        end else if (a >= 18'(FULL_TURN)) begin
            a = a - 18'(FULL_TURN);
        end
        if (a >= 18'(3 * QUARTER_TURN)) begin
            c.quad = 2'd3;
            r      = a - 18'(3 * QUARTER_TURN);
        end else if (a >= 18'(2 * QUARTER_TURN)) begin
            c.quad = 2'd2;
            r      = a - 18'(2 * QUARTER_TURN);
        end else if (a >= 18'(QUARTER_TURN)) begin
            c.quad = 2'd1;
            r      = a - 18'(QUARTER_TURN);
        end else begin
            c.quad = 2'd0;
            r      = a;
        end
        c.x = VEC_W'(CORDIC_ONE);
        c.y = '0;
        c.z = {1'b0, r[12:0], 10'd0};
        return c;
    endfunction

    always_ff @(posedge aclk) begin
        if (en) begin
            pitch_o <= start(pitch_angle);
            yaw_o   <= start(yaw_angle);
            roll_o  <= start(roll_angle);
        end
    end

endmodule

// ----- hdl/eul2rm_cell.sv -----
// ----------------------------------------------------------------------------
// eul2rm_cell
// One cordic rotation step with its own shift and arctangent constant.
// ----------------------------------------------------------------------------
module eul2rm_cell
    import eul2rm_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  logic  aclk,
    input  logic  en,
    input  cord_t d_i,
    output cord_t d_o
);

    localparam logic signed [Z_W-1:0] ATAN = Z_W'(ATAN_TBL[IDX]);

    cord_t nxt;

    always_comb begin
        nxt.quad = d_i.quad;
        if (d_i.z >= 0) begin
            nxt.x = d_i.x - (d_i.y >>> IDX);
            nxt.y = d_i.y + (d_i.x >>> IDX);
            nxt.z = d_i.z - ATAN;
        end else begin
            nxt.x = d_i.x + (d_i.y >>> IDX);
            nxt.y = d_i.y - (d_i.x >>> IDX);
            nxt.z = d_i.z + ATAN;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_o <= nxt;
        end
    end

endmodule

// ----- hdl/eul2rm_mat.sv -----
// ----------------------------------------------------------------------------
// eul2rm_mat
// Quadrant fix-up, product tree and output rounding for the nine entries.
// ----------------------------------------------------------------------------
module eul2rm_mat
    import eul2rm_pkg::*;
#(
    parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
)
(
    input  logic                   aclk,
    input  logic                   en,
    input  cord_t                  pitch_i,
    input  cord_t                  yaw_i,
    input  cord_t                  roll_i,
    output logic [NOUT*OUT_W-1:0]  tdata_o
);

    localparam int SH = 30 - OUT_FRAC_BITS;
    localparam logic signed [VEC_W:0] HALF =
        (SH > 0) ? ((VEC_W+1)'(1) <<< ((SH > 0) ? SH - 1 : 0)) : '0;
    localparam logic signed [VEC_W:0] LIM = (VEC_W+1)'(1) <<< OUT_FRAC_BITS;

    typedef logic signed [VEC_W-1:0] v_t;
    typedef logic signed [VEC_W:0]   w_t;

    v_t cp_reg, sp_reg, cy_reg, sy_reg, cr_reg, sr_reg;
    v_t spsr_reg, spcr_reg, cycr_reg, cpsr_reg, sycr_reg, cysr_reg;
    v_t cpcr_reg, sysr_reg, sycp_reg, cycp_reg, cy2_reg, sy2_reg;
    w_t nsp_reg, nsp2_reg;
    v_t cycr3_reg, cpsr3_reg, sycr3_reg, cysr3_reg, cpcr3_reg, sysr3_reg;
    v_t sycp3_reg, cycp3_reg;
    v_t b_syspsr_reg, b_cyspsr_reg, b_syspcr_reg, b_cyspcr_reg;
    logic [NOUT*OUT_W-1:0] out_reg;

    function automatic v_t quad_c(input cord_t d);
        case (d.quad)
            2'd0:    return d.x;
            2'd1:    return -d.y;
            2'd2:    return -d.x;
            default: return d.y;
        endcase
    endfunction

    function automatic v_t quad_s(input cord_t d);
        case (d.quad)
            2'd0:    return d.y;
            2'd1:    return d.x;
            2'd2:    return -d.y;
            default: return -d.x;
        endcase
    endfunction

    function automatic logic [OUT_W-1:0] to_out(input w_t v);
        w_t t;
        t = v;
        if (SH > 0) begin
            t = (t + HALF) >>> SH;
        end
        if (t > LIM) begin
            t = LIM;
        end
        if (t < -LIM) begin
            t = -LIM;
        end
        return t[OUT_W-1:0];
    endfunction

    always_ff @(posedge aclk) begin
        if (en) begin
            // quadrant swap and sign
            cp_reg <= quad_c(pitch_i);
            sp_reg <= quad_s(pitch_i);
            cy_reg <= quad_c(yaw_i);
            sy_reg <= quad_s(yaw_i);
            cr_reg <= quad_c(roll_i);
            sr_reg <= quad_s(roll_i);
            // first products
            spsr_reg <= mulq30(sp_reg, sr_reg);
            spcr_reg <= mulq30(sp_reg, cr_reg);
            cycr_reg <= mulq30(cy_reg, cr_reg);
            cpsr_reg <= mulq30(cp_reg, sr_reg);
            sycr_reg <= mulq30(sy_reg, cr_reg);
            cysr_reg <= mulq30(cy_reg, sr_reg);
            cpcr_reg <= mulq30(cp_reg, cr_reg);
            sysr_reg <= mulq30(sy_reg, sr_reg);
            sycp_reg <= mulq30(sy_reg, cp_reg);
            cycp_reg <= mulq30(cy_reg, cp_reg);
            cy2_reg  <= cy_reg;
            sy2_reg  <= sy_reg;
            nsp_reg  <= -w_t'(sp_reg);
            // triple products with the yaw term
            b_syspsr_reg <= mulq30(sy2_reg, spsr_reg);
            b_cyspsr_reg <= mulq30(cy2_reg, spsr_reg);
            b_syspcr_reg <= mulq30(sy2_reg, spcr_reg);
            b_cyspcr_reg <= mulq30(cy2_reg, spcr_reg);
            cycr3_reg <= cycr_reg;
            cpsr3_reg <= cpsr_reg;
            sycr3_reg <= sycr_reg;
            cysr3_reg <= cysr_reg;
            cpcr3_reg <= cpcr_reg;
            sysr3_reg <= sysr_reg;
            sycp3_reg <= sycp_reg;
            cycp3_reg <= cycp_reg;
            nsp2_reg  <= nsp_reg;
            // sums and rounding to the output format
            out_reg <= {
                to_out(w_t'(cycp3_reg)),
                to_out(nsp2_reg),
                to_out(w_t'(sycp3_reg)),
                to_out(w_t'(sysr3_reg) + w_t'(b_cyspcr_reg)),
                to_out(w_t'(cpcr3_reg)),
                to_out(w_t'(b_syspcr_reg) - w_t'(cysr3_reg)),
                to_out(w_t'(b_cyspsr_reg) - w_t'(sycr3_reg)),
                to_out(w_t'(cpsr3_reg)),
                to_out(w_t'(cycr3_reg) + w_t'(b_syspsr_reg))
            };
        end
    end

    assign tdata_o = out_reg;

endmodule

// ----- hdl/euler_to_rotation_matrix_top.sv -----
// ----------------------------------------------------------------------------
// euler_to_rotation_matrix_top
// Euler angles (yaw-pitch-roll, y-x-z order) to a 3x3 rotation matrix.
// ----------------------------------------------------------------------------
// Input stream s_*: one request per orientation, tdata holds pitch, yaw and
// roll, each a signed 16-bit angle in 1/64 degree. Output stream m_*: one
// result per request, tdata holds the nine entries m00 m10 m20 m01 m11 m21
// m02 m12 m22, signed with OUT_FRAC_BITS fraction bits, clamped to +-1.
// The pipeline is one wrap stage, 23 cordic cells (one per rotation
// step, all three angles side by side), quadrant fix-up, two multiply stages
// and the output register. Throughput is one request per cycle while the
// receiver does not stall; the length of the cordic chain sets the latency.
// The whole pipeline advances as one while the output register is empty or
// being taken, so a receiver stall freezes every stage and drops s_tready in
// the same cycle; no request is lost. Reset clears the valid flags only, the
// output shows nothing until the first request has passed through.
// ----------------------------------------------------------------------------
module euler_to_rotation_matrix_top
    import eul2rm_pkg::*;
#(
    parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
)
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // pitch_angle [15:0], yaw_angle [31:16], roll_angle [47:32]
    input  logic [3*ANG_W-1:0]    s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // m00, m10, m20, m01, m11, m21, m02, m12, m22, 16 bits each from bit 0
    output logic [NOUT*OUT_W-1:0] m_tdata
);

    logic                en;
    logic [LATENCY-1:0]  vld_reg;
    logic [LATENCY-1:0]  vld_next;
    cord_t               pch [CORDIC_ITERS+1];
    cord_t               yaw [CORDIC_ITERS+1];
    cord_t               rol [CORDIC_ITERS+1];

    assign en       = !vld_reg[LATENCY-1] || m_tready;
    assign s_tready = en;
    assign vld_next = {vld_reg[LATENCY-2:0], s_tvalid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= vld_next;
        end
    end

    eul2rm_wrap u_wrap (
        .aclk        (aclk),
        .en          (en),
        .pitch_angle (s_tdata[ANG_W-1:0]),
        .yaw_angle   (s_tdata[2*ANG_W-1:ANG_W]),
        .roll_angle  (s_tdata[3*ANG_W-1:2*ANG_W]),
        .pitch_o     (pch[0]),
        .yaw_o       (yaw[0]),
        .roll_o      (rol[0])
    );

    for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_chain
        eul2rm_cell #(.IDX(i)) u_cell_p (
            .aclk (aclk), .en (en), .d_i (pch[i]), .d_o (pch[i+1])
        );
        eul2rm_cell #(.IDX(i)) u_cell_y (
            .aclk (aclk), .en (en), .d_i (yaw[i]), .d_o (yaw[i+1])
        );
        eul2rm_cell #(.IDX(i)) u_cell_r (
            .aclk (aclk), .en (en), .d_i (rol[i]), .d_o (rol[i+1])
        );
    end

    eul2rm_mat #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_mat (
        .aclk    (aclk),
        .en      (en),
        .pitch_i (pch[CORDIC_ITERS]),
        .yaw_i   (yaw[CORDIC_ITERS]),
        .roll_i  (rol[CORDIC_ITERS]),
        .tdata_o (m_tdata)
    );

    assign m_tvalid = vld_reg[LATENCY-1];

endmodule

// ----- hdl/eul2rm_chk.sv -----
// ----------------------------------------------------------------------------
// eul2rm_chk
// Port-level checks for the euler to matrix block, bound to the top level.
// ----------------------------------------------------------------------------
module eul2rm_chk
    import eul2rm_pkg::*;
#(
    parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
)
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [NOUT*OUT_W-1:0] m_tdata
);

    localparam int LIMV = 1 << OUT_FRAC_BITS;

    logic signed [OUT_W-1:0] m00;
    logic signed [OUT_W-1:0] m11;
    assign m00 = m_tdata[OUT_W-1:0];
    assign m11 = m_tdata[5*OUT_W-1:4*OUT_W];

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result shown right after reset");

    // input side only waits on a full, stalled output
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input stalled without output backpressure");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // entries m00 and m11 stay clamped to plus or minus one (OUT_FRAC_BITS <= 14)
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (OUT_FRAC_BITS > 14) ||
            (int'(m00) <= LIMV && int'(m00) >= -LIMV &&
             int'(m11) <= LIMV && int'(m11) >= -LIMV))
        else $error("matrix entry beyond unit range");

    // s_tvalid is only looked at together with s_tready, which must be known then
    a_accept_known: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |-> !$isunknown(s_tready))
        else $error("unknown ready on an accepted request");

endmodule

bind euler_to_rotation_matrix_top eul2rm_chk #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
